### rtl/mjm_pkg.sv
`default_nettype none

package mjm_pkg;

   localparam int IN_W      = 16;
   localparam int DZ_W      = 14;
   localparam int MLS_W     = 15;
   localparam int MFS_W     = 16;
   localparam int SPEED_W   = 16;
   localparam int PEAK_W    = 16;
   localparam int SCALE_W   = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int AXES      = 3;
   localparam int WHEELS    = 4;

   localparam logic [DZ_W-1:0]  DZ_RESET  = 14'd1638;
   localparam logic [MLS_W-1:0] MLS_RESET = 15'd16384;
   localparam logic [MFS_W-1:0] MFS_RESET = 16'd1000;

   localparam logic [PEAK_W-1:0]  PEAK_MAX  = 16'hFFFF;
   localparam logic [SCALE_W-1:0] SCALE_MAX = 15'h7FFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEADZONE    = 2'd0,
      CSR_MAX_LINEAR  = 2'd1,
      CSR_MOTOR_SCALE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FRONT_LEFT  = 2'd0,
      FRONT_RIGHT = 2'd1,
      REAR_LEFT   = 2'd2,
      REAR_RIGHT  = 2'd3
   } wheel_type;

endpackage

`default_nettype wire

### rtl/mjm_frac_div.sv
`default_nettype none

// fractional divider: quot = floor(num * 2**QW / den), num below den
module mjm_frac_div #(
   parameter int W     = 15,
   parameter int QW    = 14,
   parameter int LANES = 1,
   parameter int SW    = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [W-1:0]  in_num  [LANES],
   input  logic [W-1:0]  in_den  [LANES],
   input  logic [SW-1:0] in_side,
   output logic          out_vld,
   output logic [QW-1:0] out_quot [LANES],
   output logic [SW-1:0] out_side
);

   logic [QW-1:0] vld_ff;
   logic [W-1:0]  rem_ff [QW][LANES];
   logic [W-1:0]  rem_in [QW][LANES];
   logic [W-1:0]  den_ff [QW][LANES];
   logic [W-1:0]  den_in [QW][LANES];
   logic [QW-1:0] quo_ff [QW][LANES];
   logic [QW-1:0] quo_in [QW][LANES];
   logic [SW-1:0] side_ff [QW];

   always_comb begin
      logic [W:0]    twice;
      logic          ge;
      logic [W-1:0]  cr;
      logic [W-1:0]  cd;
      logic [QW-1:0] cq;
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < LANES; l++) begin
            if (k == 0) begin
               cr = in_num[l];
               cd = in_den[l];
               cq = '0;
            end else begin
               cr = rem_ff[k-1][l];
               cd = den_ff[k-1][l];
               cq = quo_ff[k-1][l];
            end
            twice = {cr, 1'b0};
            ge = twice >= {1'b0, cd};
            rem_in[k][l] = ge ? W'(twice - {1'b0, cd}) : W'(twice);
            den_in[k][l] = cd;
            quo_in[k][l] = {cq[QW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QW-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         quo_ff <= quo_in;
         side_ff[0] <= in_side;
         for (int k = 1; k < QW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign out_quot = quo_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

`default_nettype wire

### rtl/mjm_isqrt.sv
`default_nettype none

// pipelined integer square root, one root bit per stage
module mjm_isqrt #(
   parameter int RW = 15,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_vld,
   input  logic [2*RW-1:0] in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_vld,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);

   localparam int NW = 2 * RW;

   logic [RW-1:0] vld_ff;
   logic [NW-1:0] rem_ff  [RW];
   logic [NW-1:0] rem_in  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [RW-1:0] root_in [RW];
   logic [SW-1:0] side_ff [RW];

   always_comb begin
      logic [NW:0]   trial;
      logic          ge;
      logic [NW-1:0] crem;
      logic [RW-1:0] croot;
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            crem  = in_rad;
            croot = '0;
         end else begin
            crem  = rem_ff[k-1];
            croot = root_ff[k-1];
         end
         trial = ((NW+1)'(croot) << (RW - k)) + ((NW+1)'(1) << (2 * (RW - 1 - k)));
         ge = (NW+1)'(crem) >= trial;
         rem_in[k]  = ge ? NW'((NW+1)'(crem) - trial) : crem;
         root_in[k] = ge ? (croot | (RW'(1) << (RW - 1 - k))) : croot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RW-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff[0] <= in_side;
         for (int k = 1; k < RW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_vld  = vld_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];

endmodule

`default_nettype wire

### rtl/mjm_int_div.sv
`default_nettype none

// pipelined restoring divider, quotient known to fit in QW bits
module mjm_int_div #(
   parameter int NW    = 30,
   parameter int DW    = 15,
   parameter int QW    = 15,
   parameter int LANES = 1,
   parameter int SW    = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [NW-1:0] in_num  [LANES],
   input  logic [DW-1:0] in_den  [LANES],
   input  logic [SW-1:0] in_side,
   output logic          out_vld,
   output logic [QW-1:0] out_quot [LANES],
   output logic [SW-1:0] out_side
);

   localparam int RW = (NW > DW + QW) ? NW : DW + QW;

   logic [QW-1:0] vld_ff;
   logic [RW-1:0] rem_ff [QW][LANES];
   logic [RW-1:0] rem_in [QW][LANES];
   logic [DW-1:0] den_ff [QW][LANES];
   logic [DW-1:0] den_in [QW][LANES];
   logic [QW-1:0] quo_ff [QW][LANES];
   logic [QW-1:0] quo_in [QW][LANES];
   logic [SW-1:0] side_ff [QW];

   always_comb begin
      logic [RW-1:0] shd;
      logic          ge;
      logic [RW-1:0] crem;
      logic [DW-1:0] cd;
      logic [QW-1:0] cq;
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < LANES; l++) begin
            if (k == 0) begin
               crem = RW'(in_num[l]);
               cd   = in_den[l];
               cq   = '0;
            end else begin
               crem = rem_ff[k-1][l];
               cd   = den_ff[k-1][l];
               cq   = quo_ff[k-1][l];
            end
            shd = RW'(cd) << (QW - 1 - k);
            ge = crem >= shd;
            rem_in[k][l] = ge ? crem - shd : crem;
            den_in[k][l] = cd;
            quo_in[k][l] = ge ? (cq | (QW'(1) << (QW - 1 - k))) : cq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QW-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         quo_ff <= quo_in;
         side_ff[0] <= in_side;
         for (int k = 1; k < QW; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign out_quot = quo_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

`default_nettype wire

### rtl/mecanum_joystick_mixer_core.sv
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req_stick_x, req_stick_y, req_stick_turn
// rsp       out        rsp_valid / rsp_ready   per wheel reverse + speed, peak, norm scale
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// one word enters per cycle while rsp does not stall; the pipeline depth comes mostly from
// the three bit-per-stage dividers and the bit-per-stage square root
// every stage moves on one shared enable: while rsp holds a word that is not taken,
// the whole pipeline and req_ready stall together, bubbles included
// reset clears the valid bits and loads the register reset values; csr_ready is always high
`default_nettype none

module mecanum_joystick_mixer_core #(
   parameter int FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [mjm_pkg::IN_W-1:0]   req_stick_x,
   input  logic signed [mjm_pkg::IN_W-1:0]   req_stick_y,
   input  logic signed [mjm_pkg::IN_W-1:0]   req_stick_turn,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_front_left_reverse,
   output logic [mjm_pkg::SPEED_W-1:0]       rsp_front_left_speed,
   output logic                              rsp_front_right_reverse,
   output logic [mjm_pkg::SPEED_W-1:0]       rsp_front_right_speed,
   output logic                              rsp_rear_left_reverse,
   output logic [mjm_pkg::SPEED_W-1:0]       rsp_rear_left_speed,
   output logic                              rsp_rear_right_reverse,
   output logic [mjm_pkg::SPEED_W-1:0]       rsp_rear_right_speed,
   output logic [mjm_pkg::PEAK_W-1:0]        rsp_peak_wheel_speed,
   output logic [mjm_pkg::SCALE_W-1:0]       rsp_norm_scale,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mjm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mjm_pkg::CSR_DATA_W-1:0]    csr_data
);

   import mjm_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int AW  = F + 1;          // axis magnitude, up to one
   localparam int VW  = F + 2;          // signed axis
   localparam int SQ1 = 2 * F + 1;      // one square
   localparam int SQW = 2 * F + 2;      // sum of squares
   localparam int PW  = AW + MLS_W;     // axis times length limit
   localparam int WW  = F + 3;          // signed wheel
   localparam int MW  = F + 2;          // wheel magnitude
   localparam int SCL = F + 1;          // scale factor
   localparam int NPW = MW + SCL;
   localparam int SPW = AW + MFS_W;
   localparam int CW  = (F + 2 > 17) ? F + 2 : 17;
   localparam int PCW = (MW > 17) ? MW : 17;
   localparam int SCW = (SCL > 16) ? SCL : 16;
   localparam logic [CW-1:0] ONE_C = CW'(1) << F;

   typedef struct packed {
      logic [AXES-1:0] neg;
      logic [AXES-1:0] zero;
      logic [AXES-1:0] one;
   } ax_side_type;

   typedef struct packed {
      logic [VW-1:0] x;
      logic [VW-1:0] y;
      logic [VW-1:0] t;
   } vec_side_type;

   typedef struct packed {
      logic          gt;
      logic [VW-1:0] x;
      logic [VW-1:0] y;
      logic [VW-1:0] t;
   } lim_side_type;

   typedef struct packed {
      logic [WHEELS-1:0][MW-1:0] mag;
      logic [WHEELS-1:0]         neg;
      logic                      big;
      logic [MW-1:0]             peak;
   } norm_side_type;

   logic [DZ_W-1:0]  dz_ff;
   logic [MLS_W-1:0] mls_ff;
   logic [MFS_W-1:0] mfs_ff;
   logic             adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff  <= DZ_RESET;
         mls_ff <= MLS_RESET;
         mfs_ff <= MFS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEADZONE:    dz_ff  <= csr_data[DZ_W-1:0];
            CSR_MAX_LINEAR:  mls_ff <= csr_data[MLS_W-1:0];
            CSR_MOTOR_SCALE: mfs_ff <= csr_data[MFS_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // stage 1: deadzone classification
   logic signed [IN_W-1:0] stick [AXES];
   logic [AW-1:0]    s1_num_in [AXES];
   logic [AW-1:0]    s1_den_in [AXES];
   ax_side_type      s1_side_in;
   logic             s1_vld_ff;
   logic [AW-1:0]    s1_num_ff [AXES];
   logic [AW-1:0]    s1_den_ff [AXES];
   ax_side_type      s1_side_ff;

   assign stick[0] = req_stick_x;
   assign stick[1] = req_stick_y;
   assign stick[2] = req_stick_turn;

   always_comb begin
      logic [IN_W-1:0] mag16;
      logic [CW-1:0]   mag_c;
      logic [CW-1:0]   dz_c;
      dz_c = CW'(dz_ff);
      for (int a = 0; a < AXES; a++) begin
         mag16 = stick[a][IN_W-1] ? IN_W'(-stick[a]) : IN_W'(stick[a]);
         mag_c = CW'(mag16);
         s1_side_in.neg[a]  = stick[a][IN_W-1];
         s1_side_in.zero[a] = mag_c < dz_c;
         s1_side_in.one[a]  = mag_c >= ONE_C;
         s1_num_in[a] = AW'(mag_c - dz_c);
         s1_den_in[a] = AW'(ONE_C - dz_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_num_ff  <= s1_num_in;
         s1_den_ff  <= s1_den_in;
         s1_side_ff <= s1_side_in;
      end
   end

   logic                          dz_vld;
   logic [F-1:0]                  dz_quot [AXES];
   logic [$bits(ax_side_type)-1:0] dz_side_raw;
   ax_side_type                   dz_side;

   mjm_frac_div #(
      .W(AW), .QW(F), .LANES(AXES), .SW($bits(ax_side_type))
   ) u_dz_div (
      .clock(clock), .reset(reset), .en(adv),
      .in_vld(s1_vld_ff), .in_num(s1_num_ff), .in_den(s1_den_ff), .in_side(s1_side_ff),
      .out_vld(dz_vld), .out_quot(dz_quot), .out_side(dz_side_raw)
   );

   assign dz_side = ax_side_type'(dz_side_raw);

   // stage 2: shaped axes and squares
   logic signed [VW-1:0] s2_v_in [AXES];
   logic [SQ1-1:0]       s2_sqx_in;
   logic [SQ1-1:0]       s2_sqy_in;
   logic                 s2_vld_ff;
   logic signed [VW-1:0] s2_v_ff [AXES];
   logic [SQ1-1:0]       s2_sqx_ff;
   logic [SQ1-1:0]       s2_sqy_ff;

   always_comb begin
      logic [AW-1:0]          r;
      logic [VW-1:0]          rv;
      logic signed [2*VW-1:0] sqx_full;
      logic signed [2*VW-1:0] sqy_full;
      for (int a = 0; a < AXES; a++) begin
         if (dz_side.zero[a]) begin
            r = '0;
         end else if (dz_side.one[a]) begin
            r = AW'(ONE_C);
         end else begin
            r = AW'(dz_quot[a]);
         end
         rv = VW'(r);
         s2_v_in[a] = dz_side.neg[a] ? ~rv + VW'(1) : rv;
      end
      sqx_full = s2_v_in[0] * s2_v_in[0];
      sqy_full = s2_v_in[1] * s2_v_in[1];
      s2_sqx_in = SQ1'(sqx_full);
      s2_sqy_in = SQ1'(sqy_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= dz_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_v_ff   <= s2_v_in;
         s2_sqx_ff <= s2_sqx_in;
         s2_sqy_ff <= s2_sqy_in;
      end
   end

   // vector length
   logic [SQW-1:0]                  rad;
   vec_side_type                    sq_side_in;
   logic                            sq_vld;
   logic [AW-1:0]                   sq_root;
   logic [$bits(vec_side_type)-1:0] sq_side_raw;
   vec_side_type                    sq_side;

   assign rad = SQW'(s2_sqx_ff) + SQW'(s2_sqy_ff);
   assign sq_side_in.x = s2_v_ff[0];
   assign sq_side_in.y = s2_v_ff[1];
   assign sq_side_in.t = s2_v_ff[2];

   mjm_isqrt #(
      .RW(AW), .SW($bits(vec_side_type))
   ) u_isqrt (
      .clock(clock), .reset(reset), .en(adv),
      .in_vld(s2_vld_ff), .in_rad(rad), .in_side(sq_side_in),
      .out_vld(sq_vld), .out_root(sq_root), .out_side(sq_side_raw)
   );

   assign sq_side = vec_side_type'(sq_side_raw);

   // stage 4: length limit products
   logic [PW-1:0] s4_p_in [2];
   lim_side_type  s4_side_in;
   logic          s4_vld_ff;
   logic [PW-1:0] s4_p_ff [2];
   logic [AW-1:0] s4_len_ff [2];
   lim_side_type  s4_side_ff;

   always_comb begin
      logic [AW-1:0] ax;
      logic [AW-1:0] ay;
      ax = sq_side.x[VW-1] ? AW'(-sq_side.x) : AW'(sq_side.x);
      ay = sq_side.y[VW-1] ? AW'(-sq_side.y) : AW'(sq_side.y);
      s4_p_in[0] = ax * mls_ff;
      s4_p_in[1] = ay * mls_ff;
      s4_side_in.gt = CW'(sq_root) > CW'(mls_ff);
      s4_side_in.x  = sq_side.x;
      s4_side_in.y  = sq_side.y;
      s4_side_in.t  = sq_side.t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_p_ff      <= s4_p_in;
         s4_len_ff[0] <= sq_root;
         s4_len_ff[1] <= sq_root;
         s4_side_ff   <= s4_side_in;
      end
   end

   logic                            id_vld;
   logic [AW-1:0]                   id_quot [2];
   logic [$bits(lim_side_type)-1:0] id_side_raw;
   lim_side_type                    id_side;

   mjm_int_div #(
      .NW(PW), .DW(AW), .QW(AW), .LANES(2), .SW($bits(lim_side_type))
   ) u_lim_div (
      .clock(clock), .reset(reset), .en(adv),
      .in_vld(s4_vld_ff), .in_num(s4_p_ff), .in_den(s4_len_ff), .in_side(s4_side_ff),
      .out_vld(id_vld), .out_quot(id_quot), .out_side(id_side_raw)
   );

   assign id_side = lim_side_type'(id_side_raw);

   // stage 5: wheel mix
   logic signed [WW-1:0] s5_w_in [WHEELS];
   logic                 s5_vld_ff;
   logic signed [WW-1:0] s5_w_ff [WHEELS];

   always_comb begin
      logic [VW-1:0]        qxv;
      logic [VW-1:0]        qyv;
      logic signed [VW-1:0] sx;
      logic signed [VW-1:0] sy;
      logic signed [VW-1:0] st;
      logic signed [WW-1:0] ex;
      logic signed [WW-1:0] ey;
      logic signed [WW-1:0] et;
      qxv = VW'(id_quot[0]);
      qyv = VW'(id_quot[1]);
      sx = id_side.gt ? (id_side.x[VW-1] ? ~qxv + VW'(1) : qxv) : id_side.x;
      sy = id_side.gt ? (id_side.y[VW-1] ? ~qyv + VW'(1) : qyv) : id_side.y;
      st = id_side.t;
      ex = WW'(sx);
      ey = WW'(sy);
      et = WW'(st);
      s5_w_in[FRONT_LEFT]  = ey - ex - et;
      s5_w_in[FRONT_RIGHT] = ey + ex + et;
      s5_w_in[REAR_LEFT]   = ey + ex - et;
      s5_w_in[REAR_RIGHT]  = ey - ex + et;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= id_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_w_ff <= s5_w_in;
      end
   end

   // stage 6: magnitudes and peak
   norm_side_type s6_side_in;
   logic          s6_vld_ff;
   norm_side_type s6_side_ff;

   always_comb begin
      logic [MW-1:0] m01;
      logic [MW-1:0] m23;
      for (int i = 0; i < WHEELS; i++) begin
         s6_side_in.neg[i] = s5_w_ff[i][WW-1];
         s6_side_in.mag[i] = s5_w_ff[i][WW-1] ? MW'(-s5_w_ff[i]) : MW'(s5_w_ff[i]);
      end
      m01 = (s6_side_in.mag[0] > s6_side_in.mag[1]) ? s6_side_in.mag[0] : s6_side_in.mag[1];
      m23 = (s6_side_in.mag[2] > s6_side_in.mag[3]) ? s6_side_in.mag[2] : s6_side_in.mag[3];
      s6_side_in.peak = (m01 > m23) ? m01 : m23;
      s6_side_in.big  = CW'(s6_side_in.peak) > ONE_C;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_side_ff <= s6_side_in;
      end
   end

   logic [MW-1:0]                    nd_num [1];
   logic [MW-1:0]                    nd_den [1];
   logic                             nd_vld;
   logic [F-1:0]                     nd_quot [1];
   logic [$bits(norm_side_type)-1:0] nd_side_raw;
   norm_side_type                    nd_side;

   assign nd_num[0] = MW'(ONE_C);
   assign nd_den[0] = s6_side_ff.peak;

   mjm_frac_div #(
      .W(MW), .QW(F), .LANES(1), .SW($bits(norm_side_type))
   ) u_norm_div (
      .clock(clock), .reset(reset), .en(adv),
      .in_vld(s6_vld_ff), .in_num(nd_num), .in_den(nd_den), .in_side(s6_side_ff),
      .out_vld(nd_vld), .out_quot(nd_quot), .out_side(nd_side_raw)
   );

   assign nd_side = norm_side_type'(nd_side_raw);

   // stage 7: apply normalisation factor
   logic [NPW-1:0]    s7_prod_in [WHEELS];
   logic [SCL-1:0]    s7_scale_in;
   logic              s7_vld_ff;
   logic [NPW-1:0]    s7_prod_ff [WHEELS];
   logic [WHEELS-1:0] s7_neg_ff;
   logic [MW-1:0]     s7_peak_ff;
   logic [SCL-1:0]    s7_scale_ff;

   always_comb begin
      s7_scale_in = nd_side.big ? SCL'(nd_quot[0]) : SCL'(ONE_C);
      for (int i = 0; i < WHEELS; i++) begin
         s7_prod_in[i] = nd_side.mag[i] * s7_scale_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= nd_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_prod_ff  <= s7_prod_in;
         s7_neg_ff   <= nd_side.neg;
         s7_peak_ff  <= nd_side.peak;
         s7_scale_ff <= s7_scale_in;
      end
   end

   // stage 8: motor units
   logic [SPW-1:0]    s8_sp_in [WHEELS];
   logic [WHEELS-1:0] s8_rev_in;
   logic              s8_vld_ff;
   logic [SPW-1:0]    s8_sp_ff [WHEELS];
   logic [WHEELS-1:0] s8_rev_ff;
   logic [MW-1:0]     s8_peak_ff;
   logic [SCL-1:0]    s8_scale_ff;

   always_comb begin
      logic [AW-1:0] nm;
      for (int i = 0; i < WHEELS; i++) begin
         nm = s7_prod_ff[i][2*F:F];
         s8_sp_in[i]  = nm * mfs_ff;
         // truncation toward zero can leave a negative wheel at zero
         s8_rev_in[i] = s7_neg_ff[i] && (nm != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_sp_ff    <= s8_sp_in;
         s8_rev_ff   <= s8_rev_in;
         s8_peak_ff  <= s7_peak_ff;
         s8_scale_ff <= s7_scale_ff;
      end
   end

   // output word register
   logic [SPEED_W-1:0] out_speed_in [WHEELS];
   logic [PEAK_W-1:0]  out_peak_in;
   logic [SCALE_W-1:0] out_scale_in;
   logic               rsp_valid_ff;
   logic [SPEED_W-1:0] out_speed_ff [WHEELS];
   logic [WHEELS-1:0]  out_rev_ff;
   logic [PEAK_W-1:0]  out_peak_ff;
   logic [SCALE_W-1:0] out_scale_ff;

   always_comb begin
      logic [PCW-1:0] pk;
      logic [SCW-1:0] sc;
      for (int i = 0; i < WHEELS; i++) begin
         out_speed_in[i] = s8_sp_ff[i][F+SPEED_W-1:F];
      end
      pk = PCW'(s8_peak_ff);
      sc = SCW'(s8_scale_ff);
      out_peak_in  = (pk > PCW'(PEAK_MAX)) ? PEAK_MAX : pk[PEAK_W-1:0];
      out_scale_in = (sc > SCW'(SCALE_MAX)) ? SCALE_MAX : sc[SCALE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_speed_ff <= out_speed_in;
         out_rev_ff   <= s8_rev_ff;
         out_peak_ff  <= out_peak_in;
         out_scale_ff <= out_scale_in;
      end
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_front_left_reverse  = out_rev_ff[FRONT_LEFT];
   assign rsp_front_left_speed    = out_speed_ff[FRONT_LEFT];
   assign rsp_front_right_reverse = out_rev_ff[FRONT_RIGHT];
   assign rsp_front_right_speed   = out_speed_ff[FRONT_RIGHT];
   assign rsp_rear_left_reverse   = out_rev_ff[REAR_LEFT];
   assign rsp_rear_left_speed     = out_speed_ff[REAR_LEFT];
   assign rsp_rear_right_reverse  = out_rev_ff[REAR_RIGHT];
   assign rsp_rear_right_speed    = out_speed_ff[REAR_RIGHT];
   assign rsp_peak_wheel_speed    = out_peak_ff;
   assign rsp_norm_scale          = out_scale_ff;

   // normalised wheel magnitudes never exceed one
   logic nm_ok;

   always_comb begin
      nm_ok = 1'b1;
      for (int i = 0; i < WHEELS; i++) begin
         if ((s7_prod_ff[i] >> F) > (NPW'(1) << F)) begin
            nm_ok = 1'b0;
         end
      end
   end

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      s7_vld_ff |-> nm_ok)
      else $error("normalised wheel speed above one");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s8_sp_ff[FRONT_LEFT]) && $stable(s8_rev_ff) && $stable(s8_vld_ff))
      else $error("last stage moved during a stall");

   a_bubble: assert property (@(posedge clock) disable iff (reset)
      adv && !s8_vld_ff |=> !rsp_valid)
      else $error("result word without an item behind it");

endmodule

`default_nettype wire
